FILE: src/lgew_pkg.sv
`default_nettype none

package lgew_pkg;

    localparam int MAX_SIDE      = 256;
    localparam int COORD_BITS    = $clog2(MAX_SIDE);
    localparam int SIDE_BITS     = COORD_BITS + 1;
    localparam int MAX_PARTICLES = 1024;
    localparam int PID_BITS      = $clog2(MAX_PARTICLES);
    localparam int COUNT_BITS    = PID_BITS + 1;
    localparam int DISP_BITS     = 24;
    localparam int SQ_BITS       = 2 * DISP_BITS;
    localparam int SUM_BITS      = 48;
    localparam int STATUS_BITS   = 3;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // Command codes.
    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_MOVE  = 1'b1;

    // Move directions.
    localparam logic [1:0] DIR_Y_UP   = 2'd0;
    localparam logic [1:0] DIR_Y_DOWN = 2'd1;
    localparam logic [1:0] DIR_X_UP   = 2'd2;
    localparam logic [1:0] DIR_X_DOWN = 2'd3;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_OCCUPIED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_OUTSIDE  = 3'd4;

    // Accumulator operations of the shared arithmetic unit.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUBR = 2'd3;

    typedef struct packed {
        logic                  command;
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
        logic [PID_BITS-1:0]   particle_index;
        logic [1:0]            direction;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]     status;
        logic [PID_BITS-1:0]        particle_id;
        logic [COORD_BITS-1:0]      pos_x;
        logic [COORD_BITS-1:0]      pos_y;
        logic signed [DISP_BITS-1:0] disp_x;
        logic signed [DISP_BITS-1:0] disp_y;
        logic [SUM_BITS-1:0]        sum_sq_disp;
        logic [COUNT_BITS-1:0]      placed_count;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [DISP_BITS-1:0]  disp_x;
        logic [DISP_BITS-1:0]  disp_y;
    } ptab_entry_t;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] acc_op;
    } arith_ctrl_t;

    function automatic logic [COORD_BITS-1:0] step_up(input logic [COORD_BITS-1:0] c,
                                                      input logic [SIDE_BITS-1:0] side);
        logic [SIDE_BITS-1:0] c1;
        c1 = {1'b0, c} + SIDE_BITS'(1);
        return (c1 >= side) ? '0 : c1[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] step_down(input logic [COORD_BITS-1:0] c,
                                                        input logic [SIDE_BITS-1:0] side);
        logic [SIDE_BITS-1:0] side_m1;
        side_m1 = side - SIDE_BITS'(1);
        return (c == '0 || {1'b0, c} > side) ? side_m1[COORD_BITS-1:0]
                                             : c - COORD_BITS'(1);
    endfunction

    function automatic logic [DISP_BITS-1:0] magnitude(input logic [DISP_BITS-1:0] d);
        return d[DISP_BITS-1] ? (~d + DISP_BITS'(1)) : d;
    endfunction

endpackage

`default_nettype wire

FILE: src/lgew_occ_map.sv
`default_nettype none

// Occupancy map stored one lattice row per word. A row that has never been
// written reads as all free, which stands in for clearing at reset.
module lgew_occ_map (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                rd_en,
    input  wire logic [lgew_pkg::COORD_BITS-1:0]     rd_row,
    output logic      [lgew_pkg::MAX_SIDE-1:0]       rd_data,
    input  wire logic                                wr_en,
    input  wire logic [lgew_pkg::COORD_BITS-1:0]     wr_row,
    input  wire logic [lgew_pkg::MAX_SIDE-1:0]       wr_data
);

    logic [lgew_pkg::MAX_SIDE-1:0] mem [lgew_pkg::MAX_SIDE];
    logic [lgew_pkg::MAX_SIDE-1:0] row_valid_reg;
    logic [lgew_pkg::MAX_SIDE-1:0] data_reg;
    logic                          data_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg  <= '0;
            data_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            if (rd_en) begin
                data_valid_reg <= row_valid_reg[rd_row];
            end
        end
    end

    assign rd_data = data_valid_reg ? data_reg : '0;

endmodule

`default_nettype wire

FILE: src/lgew_ptab.sv
`default_nettype none

module lgew_ptab (
    input  wire logic                              aclk,
    input  wire logic                              rd_en,
    input  wire logic [lgew_pkg::PID_BITS-1:0]     rd_addr,
    output lgew_pkg::ptab_entry_t                  rd_data,
    input  wire logic                              wr_en,
    input  wire logic [lgew_pkg::PID_BITS-1:0]     wr_addr,
    input  wire lgew_pkg::ptab_entry_t             wr_data
);

    lgew_pkg::ptab_entry_t mem [lgew_pkg::MAX_PARTICLES];
    lgew_pkg::ptab_entry_t data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

`default_nettype wire

FILE: src/lgew_arith.sv
`default_nettype none

// Shared squarer and one saturating add/subtract accumulator.
module lgew_arith (
    input  wire logic                              aclk,
    input  wire lgew_pkg::arith_ctrl_t             ctrl,
    input  wire logic [lgew_pkg::DISP_BITS-1:0]    mul_a,
    input  wire logic [lgew_pkg::SUM_BITS-1:0]     sum_in,
    output logic      [lgew_pkg::SUM_BITS-1:0]     acc
);

    logic [lgew_pkg::SQ_BITS-1:0]  prod_reg;
    logic [lgew_pkg::SQ_BITS-1:0]  prod_next;
    logic [lgew_pkg::SUM_BITS-1:0] acc_reg;
    logic [lgew_pkg::SUM_BITS-1:0] acc_next;
    logic [lgew_pkg::SUM_BITS:0]   op_a;
    logic [lgew_pkg::SUM_BITS:0]   op_b;
    logic [lgew_pkg::SUM_BITS:0]   add_out;
    logic                          is_sub;

    assign prod_next = {{lgew_pkg::DISP_BITS{1'b0}}, mul_a}
                     * {{lgew_pkg::DISP_BITS{1'b0}}, mul_a};

    // Subtraction is sum_in minus the accumulator, clamped at zero; addition
    // adds the last product and clamps at the top of the range.
    assign is_sub  = (ctrl.acc_op == lgew_pkg::ACC_SUBR);
    assign op_a    = is_sub ? {1'b0, sum_in} : {1'b0, acc_reg};
    assign op_b    = is_sub ? ~{1'b0, acc_reg}
                            : {1'b0, lgew_pkg::SUM_BITS'(prod_reg)};
    assign add_out = op_a + op_b + {{lgew_pkg::SUM_BITS{1'b0}}, is_sub};

    always_comb begin
        acc_next = acc_reg;
        unique case (ctrl.acc_op)
            lgew_pkg::ACC_HOLD: acc_next = acc_reg;
            lgew_pkg::ACC_LOAD: acc_next = lgew_pkg::SUM_BITS'(prod_reg);
            lgew_pkg::ACC_ADD: begin
                acc_next = add_out[lgew_pkg::SUM_BITS] ? lgew_pkg::SUM_MAX
                                                       : add_out[lgew_pkg::SUM_BITS-1:0];
            end
            lgew_pkg::ACC_SUBR: begin
                acc_next = add_out[lgew_pkg::SUM_BITS] ? '0
                                                       : add_out[lgew_pkg::SUM_BITS-1:0];
            end
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: src/lattice_gas_exclusion_walk.sv
`default_nettype none

// Hard-core random walk on a square periodic lattice.
// Commands arrive on the s_ channel, one transaction per command, and every
// command gives exactly one result transaction on the m_ channel. A place
// command puts the next particle on a free cell; a move command steps one
// particle by one cell with wraparound, only into a free cell.
// The lattice side is to be written through the cfg_ channel only while
// the block is idle; the block itself does not enforce this. The block
// handles one command at a time: s_ready is high only while the sequencer
// waits for a command. A refused command or an unknown particle goes
// straight to its result, and a successful move writes a second map row
// when the particle changes row. The squared displacement update runs four
// squares through one shared 24 by 24 bit squarer and one saturating adder.
// A finished result waits in the output register; a new command is accepted
// while it waits, but the next result is held until m_ready takes the first.
// Reset clears the count, the sum and the per-row valid bits of the map, so
// the whole lattice reads as free at once; no clearing pass is needed.
module lattice_gas_exclusion_walk (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire lgew_pkg::in_item_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output lgew_pkg::out_item_t                     m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lgew_pkg::SIDE_BITS-1:0]     cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRD  = 4'd1;
    localparam logic [3:0] S_MRD  = 4'd2;
    localparam logic [3:0] S_MOCC = 4'd3;
    localparam logic [3:0] S_OCLR = 4'd4;
    localparam logic [3:0] S_SQ0  = 4'd5;
    localparam logic [3:0] S_SQ1  = 4'd6;
    localparam logic [3:0] S_SQ2  = 4'd7;
    localparam logic [3:0] S_SUBT = 4'd8;
    localparam logic [3:0] S_ADD1 = 4'd9;
    localparam logic [3:0] S_ADD2 = 4'd10;
    localparam logic [3:0] S_UPD  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    localparam int CB = lgew_pkg::COORD_BITS;
    localparam int DB = lgew_pkg::DISP_BITS;
    localparam int RW = lgew_pkg::MAX_SIDE;

    logic [3:0]                        state_reg, state_next;
    logic [lgew_pkg::SIDE_BITS-1:0]    side_reg;
    logic [lgew_pkg::SIDE_BITS-1:0]    side_eff;
    logic [lgew_pkg::COUNT_BITS-1:0]   count_reg;
    logic [lgew_pkg::SUM_BITS-1:0]     sum_reg;
    lgew_pkg::in_item_t                in_reg;
    lgew_pkg::out_item_t               res_reg, res_next;
    lgew_pkg::out_item_t               out_reg;
    logic                              m_valid_reg;

    logic [CB-1:0] ox_reg, oy_reg, nx_reg, ny_reg;
    logic [DB-1:0] dx_reg, dy_reg, ndx_reg, ndy_reg;
    logic [CB-1:0] nx_calc, ny_calc;
    logic [DB-1:0] ndx_calc, ndy_calc;

    logic          accept;
    logic          place_ok;
    logic          move_ok;
    logic          same_row;

    logic          occ_rd_en, occ_wr_en;
    logic [CB-1:0] occ_rd_row, occ_wr_row;
    logic [RW-1:0] occ_rd_data, occ_wr_data;

    logic                  pt_rd_en, pt_wr_en;
    logic [lgew_pkg::PID_BITS-1:0] pt_wr_addr;
    lgew_pkg::ptab_entry_t pt_rd_data, pt_wr_data;

    lgew_pkg::arith_ctrl_t       actrl;
    logic [DB-1:0]               mul_a;
    logic [lgew_pkg::SUM_BITS-1:0] acc;

    // The side register is clamped into the legal range before any use.
    always_comb begin
        side_eff = side_reg;
        if (side_reg == '0) begin
            side_eff = lgew_pkg::SIDE_BITS'(1);
        end else if (side_reg > lgew_pkg::SIDE_BITS'(lgew_pkg::MAX_SIDE)) begin
            side_eff = lgew_pkg::SIDE_BITS'(lgew_pkg::MAX_SIDE);
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Checks made on the incoming command itself, in the order that decides
    // which refusal is reported.
    assign place_ok = ({1'b0, s_data.x_coord} < side_eff)
                   && ({1'b0, s_data.y_coord} < side_eff)
                   && (count_reg < lgew_pkg::COUNT_BITS'(lgew_pkg::MAX_PARTICLES));
    assign move_ok  = ({1'b0, s_data.particle_index} < count_reg);

    // Target cell and new counters of a move, worked out from the table entry.
    always_comb begin
        nx_calc  = pt_rd_data.pos_x;
        ny_calc  = pt_rd_data.pos_y;
        ndx_calc = pt_rd_data.disp_x;
        ndy_calc = pt_rd_data.disp_y;
        case (in_reg.direction)
            lgew_pkg::DIR_Y_UP: begin
                ny_calc  = lgew_pkg::step_up(pt_rd_data.pos_y, side_eff);
                ndy_calc = pt_rd_data.disp_y + DB'(1);
            end
            lgew_pkg::DIR_Y_DOWN: begin
                ny_calc  = lgew_pkg::step_down(pt_rd_data.pos_y, side_eff);
                ndy_calc = pt_rd_data.disp_y - DB'(1);
            end
            lgew_pkg::DIR_X_UP: begin
                nx_calc  = lgew_pkg::step_up(pt_rd_data.pos_x, side_eff);
                ndx_calc = pt_rd_data.disp_x + DB'(1);
            end
            default: begin
                nx_calc  = lgew_pkg::step_down(pt_rd_data.pos_x, side_eff);
                ndx_calc = pt_rd_data.disp_x - DB'(1);
            end
        endcase
    end

    assign same_row = (oy_reg == ny_reg);

    // Sequencer: memory ports, arithmetic control and next state.
    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        occ_rd_en   = 1'b0;
        occ_rd_row  = s_data.y_coord;
        occ_wr_en   = 1'b0;
        occ_wr_row  = in_reg.y_coord;
        occ_wr_data = occ_rd_data;
        pt_rd_en    = 1'b0;
        pt_wr_en    = 1'b0;
        pt_wr_addr  = in_reg.particle_index;
        pt_wr_data  = '{pos_x: nx_reg, pos_y: ny_reg, disp_x: ndx_reg, disp_y: ndy_reg};
        actrl       = '{mul_en: 1'b0, acc_op: lgew_pkg::ACC_HOLD};
        mul_a       = lgew_pkg::magnitude(dx_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    if (s_data.command == lgew_pkg::CMD_PLACE) begin
                        if (place_ok) begin
                            occ_rd_en  = 1'b1;
                            occ_rd_row = s_data.y_coord;
                            state_next = S_PRD;
                        end else begin
                            if (({1'b0, s_data.x_coord} >= side_eff)
                                || ({1'b0, s_data.y_coord} >= side_eff)) begin
                                res_next.status = lgew_pkg::ST_OUTSIDE;
                            end else begin
                                res_next.status = lgew_pkg::ST_FULL;
                            end
                            state_next = S_DONE;
                        end
                    end else begin
                        if (move_ok) begin
                            pt_rd_en   = 1'b1;
                            state_next = S_MRD;
                        end else begin
                            res_next.status = lgew_pkg::ST_UNKNOWN;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_PRD: begin
                if (occ_rd_data[in_reg.x_coord]) begin
                    res_next.status = lgew_pkg::ST_OCCUPIED;
                end else begin
                    occ_wr_en   = 1'b1;
                    occ_wr_row  = in_reg.y_coord;
                    occ_wr_data = occ_rd_data | (RW'(1) << in_reg.x_coord);
                    pt_wr_en    = 1'b1;
                    pt_wr_addr  = count_reg[lgew_pkg::PID_BITS-1:0];
                    pt_wr_data  = '{pos_x: in_reg.x_coord, pos_y: in_reg.y_coord,
                                    disp_x: '0, disp_y: '0};
                    res_next.status      = lgew_pkg::ST_OK;
                    res_next.particle_id = count_reg[lgew_pkg::PID_BITS-1:0];
                    res_next.pos_x       = in_reg.x_coord;
                    res_next.pos_y       = in_reg.y_coord;
                end
                state_next = S_DONE;
            end
            S_MRD: begin
                occ_rd_en  = 1'b1;
                occ_rd_row = ny_calc;
                state_next = S_MOCC;
            end
            S_MOCC: begin
                res_next.particle_id = in_reg.particle_index;
                if (occ_rd_data[nx_reg]) begin
                    // Blocked, which includes a step back onto the particle's own cell.
                    res_next.status = lgew_pkg::ST_OCCUPIED;
                    res_next.pos_x  = ox_reg;
                    res_next.pos_y  = oy_reg;
                    res_next.disp_x = dx_reg;
                    res_next.disp_y = dy_reg;
                    state_next      = S_DONE;
                end else begin
                    occ_wr_en   = 1'b1;
                    occ_wr_row  = ny_reg;
                    occ_wr_data = occ_rd_data | (RW'(1) << nx_reg);
                    if (same_row) begin
                        occ_wr_data = (occ_rd_data | (RW'(1) << nx_reg))
                                    & ~(RW'(1) << ox_reg);
                        state_next  = S_SQ0;
                    end else begin
                        occ_rd_en  = 1'b1;
                        occ_rd_row = oy_reg;
                        state_next = S_OCLR;
                    end
                    pt_wr_en        = 1'b1;
                    res_next.status = lgew_pkg::ST_OK;
                    res_next.pos_x  = nx_reg;
                    res_next.pos_y  = ny_reg;
                    res_next.disp_x = ndx_reg;
                    res_next.disp_y = ndy_reg;
                end
            end
            S_OCLR: begin
                occ_wr_en   = 1'b1;
                occ_wr_row  = oy_reg;
                occ_wr_data = occ_rd_data & ~(RW'(1) << ox_reg);
                state_next  = S_SQ0;
            end
            S_SQ0: begin
                actrl      = '{mul_en: 1'b1, acc_op: lgew_pkg::ACC_HOLD};
                mul_a      = lgew_pkg::magnitude(dx_reg);
                state_next = S_SQ1;
            end
            S_SQ1: begin
                actrl      = '{mul_en: 1'b1, acc_op: lgew_pkg::ACC_LOAD};
                mul_a      = lgew_pkg::magnitude(dy_reg);
                state_next = S_SQ2;
            end
            S_SQ2: begin
                actrl      = '{mul_en: 1'b1, acc_op: lgew_pkg::ACC_ADD};
                mul_a      = lgew_pkg::magnitude(ndx_reg);
                state_next = S_SUBT;
            end
            S_SUBT: begin
                actrl      = '{mul_en: 1'b0, acc_op: lgew_pkg::ACC_SUBR};
                state_next = S_ADD1;
            end
            S_ADD1: begin
                actrl      = '{mul_en: 1'b1, acc_op: lgew_pkg::ACC_ADD};
                mul_a      = lgew_pkg::magnitude(ndy_reg);
                state_next = S_ADD2;
            end
            S_ADD2: begin
                actrl      = '{mul_en: 1'b0, acc_op: lgew_pkg::ACC_ADD};
                state_next = S_UPD;
            end
            S_UPD: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            side_reg    <= lgew_pkg::SIDE_BITS'(lgew_pkg::MAX_SIDE);
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                side_reg <= cfg_data;
            end
            if (state_reg == S_PRD && !occ_rd_data[in_reg.x_coord]) begin
                count_reg <= count_reg + lgew_pkg::COUNT_BITS'(1);
            end
            // Once the sum has saturated it is frozen.
            if (state_reg == S_UPD && sum_reg != lgew_pkg::SUM_MAX) begin
                sum_reg <= acc;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            in_reg <= s_data;
        end
        if (state_reg == S_MRD) begin
            ox_reg  <= pt_rd_data.pos_x;
            oy_reg  <= pt_rd_data.pos_y;
            dx_reg  <= pt_rd_data.disp_x;
            dy_reg  <= pt_rd_data.disp_y;
            nx_reg  <= nx_calc;
            ny_reg  <= ny_calc;
            ndx_reg <= ndx_calc;
            ndy_reg <= ndy_calc;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            out_reg <= '{status:       res_reg.status,
                         particle_id:  res_reg.particle_id,
                         pos_x:        res_reg.pos_x,
                         pos_y:        res_reg.pos_y,
                         disp_x:       res_reg.disp_x,
                         disp_y:       res_reg.disp_y,
                         sum_sq_disp:  sum_reg,
                         placed_count: count_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    lgew_occ_map u_occ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (occ_rd_en),
        .rd_row  (occ_rd_row),
        .rd_data (occ_rd_data),
        .wr_en   (occ_wr_en),
        .wr_row  (occ_wr_row),
        .wr_data (occ_wr_data)
    );

    lgew_ptab u_ptab (
        .aclk    (aclk),
        .rd_en   (pt_rd_en),
        .rd_addr (s_data.particle_index),
        .rd_data (pt_rd_data),
        .wr_en   (pt_wr_en),
        .wr_addr (pt_wr_addr),
        .wr_data (pt_wr_data)
    );

    lgew_arith u_arith (
        .aclk   (aclk),
        .ctrl   (actrl),
        .mul_a  (mul_a),
        .sum_in (sum_reg),
        .acc    (acc)
    );

    // A command is taken only once; the sequencer is busy on the next cycle.
    a_single_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted while the sequencer was busy");

    // A saturated sum never leaves saturation.
    a_sum_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(sum_reg) == lgew_pkg::SUM_MAX) |-> (sum_reg == lgew_pkg::SUM_MAX))
        else $error("saturated sum changed");

    // The particle count only moves when a place command finds its cell free.
    a_count_on_place: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_PRD))
        else $error("particle count changed outside a place");

endmodule

`default_nettype wire

FILE: dv/tb_lattice_gas_exclusion_walk.sv
`timescale 1ns / 1ps

// Self-checking bench for the lattice gas walker with exclusion.
// Place and move commands go in on the s_ channel and every command comes back
// as exactly one result transaction on the m_ channel. An in-bench model of the
// lattice works out each result as the command transaction is accepted; the
// receiving side compares what arrives, field by field, against the oldest
// outstanding prediction.
module tb_lattice_gas_exclusion_walk;

    import lgew_pkg::*;

    // Longest run of cycles with no transaction on any channel before the run
    // is declared hung. It is generous beside the longest move and the longest
    // idle burst that either side may insert.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed to pass once the last result is in, before the verdict.
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 40;

    // One line of the directed script: either a lattice side to write, or a
    // command, optionally with its result written out by hand.
    typedef struct {
        bit                   is_cfg;
        logic [SIDE_BITS-1:0] side_val;
        in_item_t             cmd;
        bit                   typed;
        out_item_t            want;
    } script_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SIDE_BITS-1:0] cfg_data  = '0;

    // Lattice model: occupancy by cell {y, x}, the particle table, the number
    // placed, the running sum of squared displacements and the side register.
    bit                   occupied [MAX_SIDE*MAX_SIDE];
    ptab_entry_t          particles [MAX_PARTICLES];
    int                   placed    = 0;
    logic [SUM_BITS-1:0]  sum_sq    = '0;
    logic [SIDE_BITS-1:0] side_reg  = SIDE_BITS'(MAX_SIDE);

    out_item_t            pending_results [$];
    script_row_t          script [$];
    int                   status_seen [8];
    int                   items_sent  = 0;
    int                   results_got = 0;
    int                   errors      = 0;
    int                   stall_left  = 0;
    int                   mid_side    = 0;
    // When set, neither side inserts idle cycles.
    bit                   calm        = 1'b0;

    lattice_gas_exclusion_walk dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Lattice model
    // ------------------------------------------------------------------

    // The register is clamped into 1 .. MAX_SIDE before use.
    function automatic int eff_side();
        if (side_reg == '0) begin
            return 1;
        end
        if (side_reg > SIDE_BITS'(MAX_SIDE)) begin
            return MAX_SIDE;
        end
        return int'(side_reg);
    endfunction

    // One periodic step along an axis. Stepping up from a coordinate at or
    // beyond the last column wraps to zero; stepping down from zero, or from a
    // coordinate left beyond the side by an earlier, larger side, lands on the
    // last column.
    function automatic logic [COORD_BITS-1:0] wrap_step(input logic [COORD_BITS-1:0] c,
                                                        input bit up, input int s);
        int v;
        v = int'(c);
        if (up) begin
            return (v + 1 >= s) ? '0 : COORD_BITS'(v + 1);
        end
        return (v == 0 || v > s) ? COORD_BITS'(s - 1) : COORD_BITS'(v - 1);
    endfunction

    function automatic logic [63:0] squared_length(input logic signed [DISP_BITS-1:0] dx,
                                                   input logic signed [DISP_BITS-1:0] dy);
        longint a;
        longint b;
        a = dx;
        b = dy;
        return a * a + b * b;
    endfunction

    // Applies one command to the model and returns the result it should give.
    function automatic out_item_t predict_command(input in_item_t c);
        out_item_t           r;
        ptab_entry_t         e;
        int                  s;
        logic [15:0]         from_cell;
        logic [15:0]         to_cell;
        logic [63:0]         old_sq;
        logic [63:0]         new_sq;
        logic [63:0]         acc;
        r = '0;
        s = eff_side();
        if (c.command == CMD_PLACE) begin
            // Outside the lattice is checked first, then a full table, then
            // an occupied cell.
            if (int'(c.x_coord) >= s || int'(c.y_coord) >= s) begin
                r.status = ST_OUTSIDE;
            end else if (placed >= MAX_PARTICLES) begin
                r.status = ST_FULL;
            end else if (occupied[{c.y_coord, c.x_coord}]) begin
                r.status = ST_OCCUPIED;
            end else begin
                particles[placed] = '{pos_x: c.x_coord, pos_y: c.y_coord,
                                      disp_x: '0, disp_y: '0};
                occupied[{c.y_coord, c.x_coord}] = 1'b1;
                r.status      = ST_OK;
                r.particle_id = PID_BITS'(placed);
                r.pos_x       = c.x_coord;
                r.pos_y       = c.y_coord;
                placed++;
            end
        end else if (int'(c.particle_index) >= placed) begin
            r.status = ST_UNKNOWN;
        end else begin
            e = particles[c.particle_index];
            from_cell = {e.pos_y, e.pos_x};
            case (c.direction)
                DIR_Y_UP: begin
                    e.pos_y  = wrap_step(e.pos_y, 1'b1, s);
                    e.disp_y = e.disp_y + 1'b1;
                end
                DIR_Y_DOWN: begin
                    e.pos_y  = wrap_step(e.pos_y, 1'b0, s);
                    e.disp_y = e.disp_y - 1'b1;
                end
                DIR_X_UP: begin
                    e.pos_x  = wrap_step(e.pos_x, 1'b1, s);
                    e.disp_x = e.disp_x + 1'b1;
                end
                DIR_X_DOWN: begin
                    e.pos_x  = wrap_step(e.pos_x, 1'b0, s);
                    e.disp_x = e.disp_x - 1'b1;
                end
            endcase
            to_cell = {e.pos_y, e.pos_x};
            r.particle_id = c.particle_index;
            // A target cell that is taken blocks the move; on a side of one
            // that includes the particle's own cell.
            if (occupied[to_cell]) begin
                r.status = ST_OCCUPIED;
                e = particles[c.particle_index];
            end else begin
                old_sq = squared_length(particles[c.particle_index].disp_x,
                                        particles[c.particle_index].disp_y);
                new_sq = squared_length(e.disp_x, e.disp_y);
                occupied[from_cell] = 1'b0;
                occupied[to_cell]   = 1'b1;
                particles[c.particle_index] = e;
                // The sum sticks once it has saturated.
                if (sum_sq != SUM_MAX) begin
                    acc = (old_sq > sum_sq) ? 64'd0 : sum_sq - old_sq;
                    acc = (new_sq > SUM_MAX - acc) ? SUM_MAX : acc + new_sq;
                    sum_sq = acc[SUM_BITS-1:0];
                end
            end
            r.pos_x  = e.pos_x;
            r.pos_y  = e.pos_y;
            r.disp_x = e.disp_x;
            r.disp_y = e.disp_y;
        end
        r.sum_sq_disp  = sum_sq;
        r.placed_count = COUNT_BITS'(placed);
        status_seen[r.status]++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t ns: result %0d, %s expected %0h actual %0h",
                         $time, results_got, name, want, got);
            end
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t ns: result transaction with nothing expected, actual %h",
                         $time, got);
            end
        end else begin
            want = pending_results.pop_front();
            compare_field("status",       want.status,       got.status);
            compare_field("particle_id",  want.particle_id,  got.particle_id);
            compare_field("pos_x",        want.pos_x,        got.pos_x);
            compare_field("pos_y",        want.pos_y,        got.pos_y);
            compare_field("disp_x",       want.disp_x,       got.disp_x);
            compare_field("disp_y",       want.disp_y,       got.disp_y);
            compare_field("sum_sq_disp",  want.sum_sq_disp,  got.sum_sq_disp);
            compare_field("placed_count", want.placed_count, got.placed_count);
        end
        results_got++;
    endtask

    // The result side: results are taken at the edge where m_valid and m_ready
    // are both high, judged on the values before the edge. m_ready drops for
    // random bursts unless the current phase is a calm one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Ends the run if no transaction of any kind happens for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_lattice_gas_exclusion_walk: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Sends one command. Called just after a rising edge; returns at the edge
    // where the command transaction was accepted, with s_valid still high so
    // that a following command can keep it up without a glitch.
    task automatic issue(input in_item_t c, input bit typed, input out_item_t given);
        out_item_t predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_command(c);
        pending_results.push_back(typed ? given : predicted);
        items_sent++;
    endtask

    // The side may only change while the block is idle, so every outstanding
    // result is collected first. Each command yields a result as its last act,
    // so nothing is still in flight once the queue is empty.
    task automatic write_side(input logic [SIDE_BITS-1:0] v);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        side_reg = v;
    endtask

    function automatic in_item_t mk_place(input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] y);
        in_item_t c;
        c = '0;
        c.command = CMD_PLACE;
        c.x_coord = x;
        c.y_coord = y;
        return c;
    endfunction

    function automatic in_item_t mk_move(input logic [PID_BITS-1:0] p,
                                         input logic [1:0] dir);
        in_item_t c;
        c = '0;
        c.command        = CMD_MOVE;
        c.particle_index = p;
        c.direction      = dir;
        return c;
    endfunction

    function automatic out_item_t mk_out(input logic [STATUS_BITS-1:0] st,
                                         input logic [PID_BITS-1:0] id,
                                         input logic [COORD_BITS-1:0] px,
                                         input logic [COORD_BITS-1:0] py,
                                         input logic [COUNT_BITS-1:0] cnt);
        out_item_t r;
        r = '0;
        r.status       = st;
        r.particle_id  = id;
        r.pos_x        = px;
        r.pos_y        = py;
        r.placed_count = cnt;
        return r;
    endfunction

    function automatic void add_cfg(input logic [SIDE_BITS-1:0] v);
        script.push_back('{1'b1, v, '0, 1'b0, '0});
    endfunction

    function automatic void add_cmd(input in_item_t c);
        script.push_back('{1'b0, '0, c, 1'b0, '0});
    endfunction

    function automatic void add_typed(input in_item_t c, input out_item_t w);
        script.push_back('{1'b0, '0, c, 1'b1, w});
    endfunction

    // One phase of random commands at a given side. Most commands are well
    // formed: places inside the lattice and moves of particles that exist. A
    // share of places aims at a cell already taken, and a share of commands
    // is noise (coordinates anywhere in the field, any particle index).
    task automatic run_phase(input logic [SIDE_BITS-1:0] side_val, input int n,
                             input int place_pct, input bit idle_on, input bit until_full);
        in_item_t    c;
        logic [31:0] raw;
        int          s;
        int          pick;
        int          k;
        write_side(side_val);
        calm = !idle_on;
        for (int i = 0; until_full ? (placed < MAX_PARTICLES) : (i < n); i++) begin
            raw = $urandom;
            c = raw[$bits(in_item_t)-1:0];
            s = eff_side();
            if ($urandom_range(0, 99) < place_pct) begin
                c.command = CMD_PLACE;
                pick = $urandom_range(0, 99);
                if (pick < 15 && placed > 0) begin
                    k = $urandom_range(0, placed - 1);
                    c.x_coord = particles[k].pos_x;
                    c.y_coord = particles[k].pos_y;
                end else if (pick < 90) begin
                    c.x_coord = COORD_BITS'($urandom_range(0, s - 1));
                    c.y_coord = COORD_BITS'($urandom_range(0, s - 1));
                end
            end else begin
                c.command = CMD_MOVE;
                if (placed > 0 && $urandom_range(0, 99) >= 8) begin
                    c.particle_index = PID_BITS'($urandom_range(0, placed - 1));
                end
            end
            issue(c, 1'b0, '0);
        end
    endtask

    initial begin
        // Directed script. The first four results follow straight from reset
        // and are written out; the rest come from the model.
        // Reset side (256): moving before anything is placed, a first place,
        // the same cell again, and a second particle in the corner.
        add_typed(mk_move(10'd0, DIR_Y_UP), mk_out(ST_UNKNOWN, '0, '0, '0, 11'd0));
        add_typed(mk_place(8'd255, 8'd255),
                  mk_out(ST_OK, 10'd0, 8'd255, 8'd255, 11'd1));
        add_typed(mk_place(8'd255, 8'd255), mk_out(ST_OCCUPIED, '0, '0, '0, 11'd1));
        add_typed(mk_place(8'd0, 8'd0), mk_out(ST_OK, 10'd1, 8'd0, 8'd0, 11'd2));
        // Wraparound left from column zero, then a wrap upwards onto that
        // particle (blocked), then each particle stepping on into a free corner.
        add_cmd(mk_move(10'd1, DIR_X_DOWN));
        add_cmd(mk_move(10'd0, DIR_Y_UP));
        add_cmd(mk_move(10'd0, DIR_X_UP));
        add_cmd(mk_move(10'd1, DIR_Y_DOWN));
        add_cmd(mk_move(10'd1023, DIR_X_DOWN));
        // Shrink to 4: places outside in each axis, and particles sitting far
        // beyond the new side stepping up (to zero) and down (to the last row).
        add_cfg(9'd4);
        add_cmd(mk_place(8'd4, 8'd0));
        add_cmd(mk_place(8'd0, 8'd255));
        add_cmd(mk_move(10'd1, DIR_Y_UP));
        add_cmd(mk_move(10'd0, DIR_X_DOWN));
        add_cmd(mk_move(10'd0, DIR_Y_DOWN));
        add_cmd(mk_place(8'd3, 8'd3));
        add_cmd(mk_place(8'd3, 8'd2));
        add_cmd(mk_move(10'd2, DIR_Y_UP));
        // A written zero behaves as a side of one: any step lands back on the
        // particle's own cell and is blocked.
        add_cfg(9'd0);
        add_cmd(mk_place(8'd0, 8'd0));
        add_cmd(mk_place(8'd0, 8'd0));
        add_cmd(mk_place(8'd1, 8'd1));
        add_cmd(mk_move(10'd3, DIR_X_UP));
        add_cmd(mk_move(10'd3, DIR_Y_DOWN));
        // The largest register value clamps to the full lattice.
        add_cfg(9'd511);
        add_cmd(mk_place(8'd255, 8'd0));
        add_cmd(mk_place(8'd200, 8'd100));
        add_cmd(mk_move(10'd4, DIR_Y_DOWN));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                write_side(script[i].side_val);
            end else begin
                issue(script[i].cmd, script[i].typed, script[i].want);
            end
        end

        // Random phases. Small lattices crowd quickly, so moves there are
        // often blocked, and particles left beyond a later, smaller side
        // exercise the wraparound from outside. The full lattice is then
        // filled until the table is full, and a calm tail keeps placing into
        // the full table while moving particles all over the index range.
        mid_side = $urandom_range(9, 255);
        run_phase(9'd8,                   50, 35, 1'b1, 1'b0);
        run_phase(9'd2,                   25, 30, 1'b0, 1'b0);
        run_phase(9'd3,                   25, 30, 1'b1, 1'b0);
        run_phase(9'd1,                   15, 30, 1'b1, 1'b0);
        run_phase(SIDE_BITS'(mid_side),   50, 40, 1'b0, 1'b0);
        run_phase(9'd256,                  0, 97, 1'b1, 1'b1);
        run_phase(9'd300,                 40, 50, 1'b0, 1'b0);

        s_valid <= 1'b0;
        calm = 1'b1;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d commands at sides 256, 4, 0, 511, 8, 2, 3, 1, %0d, 256, 300.",
                 items_sent, mid_side);
        $display("Results: %0d done, %0d occupied or blocked, %0d full, %0d unknown, %0d outside.",
                 status_seen[ST_OK], status_seen[ST_OCCUPIED], status_seen[ST_FULL],
                 status_seen[ST_UNKNOWN], status_seen[ST_OUTSIDE]);
        if (errors == 0) begin
            $display("tb_lattice_gas_exclusion_walk: PASS");
        end else begin
            $display("tb_lattice_gas_exclusion_walk: FAIL");
        end
        $finish;
    end

endmodule
